// ----- hw/rtl/zone_table_point_and_area_match_unit_macros.svh -----
// Assertion macros for the zone table match unit.
// Used by the checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef ZONE_TABLE_POINT_AND_AREA_MATCH_UNIT_MACROS_SVH
`define ZONE_TABLE_POINT_AND_AREA_MATCH_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZTAM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZTAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ztam_pkg.sv -----
// Types and codes shared by the zone table match unit.
// No dependencies.
`default_nettype none

package ztam_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_POINT = 2'd2,
    FUNC_AREA  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  zone_index;
    logic        is_circle;
    logic [15:0] x_a;
    logic [15:0] y_a;
    logic [15:0] x_b;
    logic [15:0] y_b;
    logic [3:0]  level;
    logic [11:0] radius_in;
    logic [7:0]  ambient_in;
    logic [7:0]  color_in;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] hit_index;
    logic [7:0] hit_ambient;
    logic [7:0] hit_color;
    logic       last;
  } out_t;

  // One table entry as held in the zone memory.
  typedef struct packed {
    logic        is_circle;
    logic [15:0] x_a;
    logic [15:0] y_a;
    logic [15:0] x_b;
    logic [15:0] y_b;
    logic [3:0]  level;
    logic [11:0] radius;
    logic [7:0]  ambient;
    logic [7:0]  color;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Query held for the duration of a scan.
  typedef struct packed {
    logic        is_area;
    logic [15:0] x_a;
    logic [15:0] y_a;
    logic [15:0] x_b;
    logic [15:0] y_b;
    logic [3:0]  level;
  } query_t;

  // Side information travelling with each memory read.
  typedef struct packed {
    logic       slot_valid;
    logic       last_slot;
    logic [3:0] index;
  } tag_t;

  // Registered result of the per-entry evaluation stage.
  typedef struct packed {
    logic        slot_ok;
    logic        last_slot;
    logic [3:0]  index;
    logic        is_circle;
    logic        rect_in;
    logic        box_ok;
    logic [31:0] dx2;
    logic [31:0] dy2;
    logic [23:0] r2;
    logic [7:0]  ambient;
    logic [7:0]  color;
  } eval_t;

endpackage

`default_nettype wire

// ----- hw/rtl/zone_table_point_and_area_match_unit.sv -----
// Top level of the zone table match unit: scan sequencer, valid bits and result register.
// Depends on ztam_pkg, ztam_ram and ztam_eval.
`default_nettype none

// Usage
// A transaction is accepted on a rising edge where start is high and busy is low.
// item_i.func selects the operation. A zone write or a table clear completes at the
// accepting edge: busy stays low and the next transaction may follow in the next
// cycle. A write to a slot at or beyond NUM_ZONES is dropped.
// A point lookup or an area query raises busy and scans the zone memory one entry
// per cycle, in index order. Each entry passes through a memory read stage, an
// evaluation stage (squares and bounding box) and a decision stage, whose result
// is registered in the output register.
// Results are shown on result_o for exactly one cycle with result_valid_o high;
// the receiver cannot hold them off. A point lookup gives a single result: the
// first zone that matches, or a not-found result when nothing matches. An area
// query gives its final result at the end of the scan, and each earlier hit once
// the next hit is found. The memory read port, one entry per cycle, sets the
// length of a query.
// Reset clears all entry valid bits at once, so the table reads as empty and no
// clearing pass is needed; zone data in memory is left undefined until written.
module zone_table_point_and_area_match_unit
  import ztam_pkg::*;
#(
  parameter int unsigned NUM_ZONES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  item_i,
  output out_t      result_o,
  output logic      result_valid_o
);

  localparam int unsigned IdxW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ZONES - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] rd_cnt_q, rd_cnt_d;
  logic            rd_issue, rd_v_q;
  tag_t            tag_q;
  logic [NUM_ZONES-1:0] valid_q;
  query_t          qry_q;

  logic            accept, is_query, in_range, ram_we;
  entry_t          wr_entry, rd_entry;
  logic [EntryW-1:0] rd_data;

  logic            ev_v;
  eval_t           ev;
  logic [32:0]     dist2;
  logic            hit, done_b, flush_go;

  logic            pend_v_q;
  logic [3:0]      pend_idx_q;
  logic [7:0]      pend_amb_q, pend_col_q;

  logic            emit_v;
  out_t            emit_d;
  logic            out_v_q;
  out_t            out_q;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign is_query = (item_i.func == FUNC_POINT) || (item_i.func == FUNC_AREA);
  assign in_range = (32'(item_i.zone_index) < 32'(NUM_ZONES));
  assign ram_we   = accept && (item_i.func == FUNC_WRITE) && in_range;

  always_comb begin
    wr_entry.is_circle = item_i.is_circle;
    wr_entry.x_a       = item_i.x_a;
    wr_entry.y_a       = item_i.y_a;
    wr_entry.x_b       = item_i.x_b;
    wr_entry.y_b       = item_i.y_b;
    wr_entry.level     = item_i.level;
    wr_entry.radius    = item_i.radius_in;
    wr_entry.ambient   = item_i.ambient_in;
    wr_entry.color     = item_i.color_in;
  end

  // The zone memory is only written while idle and only read while scanning,
  // so a read never meets a write to the same entry.
  ztam_ram #(
    .Width (EntryW),
    .Depth (NUM_ZONES)
  ) u_zone_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(item_i.zone_index)),
    .wdata_i (wr_entry),
    .re_i    (rd_issue),
    .raddr_i (rd_cnt_q),
    .rdata_o (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // Valid bits live in flip-flops so that reset and a clear empty the table at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (accept && (item_i.func == FUNC_CLEAR)) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[IdxW'(item_i.zone_index)] <= 1'b1;
    end
  end

  // The query is held steady for the whole scan.
  always_ff @(posedge clk_i) begin
    if (accept && is_query) begin
      qry_q.is_area <= (item_i.func == FUNC_AREA);
      qry_q.x_a     <= item_i.x_a;
      qry_q.y_a     <= item_i.y_a;
      qry_q.x_b     <= item_i.x_b;
      qry_q.y_b     <= item_i.y_b;
      qry_q.level   <= item_i.level;
    end
  end

  // Read stage: the tag is registered alongside the memory read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      rd_cnt_q <= '0;
    end else begin
      rd_v_q   <= rd_issue;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      tag_q.slot_valid <= valid_q[rd_cnt_q];
      tag_q.last_slot  <= (rd_cnt_q == LastIdx);
      tag_q.index      <= 4'(rd_cnt_q);
    end
  end

  ztam_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q && !done_b),
    .tag_i   (tag_q),
    .entry_i (rd_entry),
    .query_i (qry_q),
    .valid_o (ev_v),
    .eval_o  (ev)
  );

  // Decision stage. A point lookup ends at its first hit, which also discards
  // the entries still in flight behind it.
  always_comb begin
    dist2    = 33'(ev.dx2) + 33'(ev.dy2);
    hit      = ev_v && ev.slot_ok &&
               (qry_q.is_area ? ev.box_ok
                              : (ev.is_circle ? (dist2 <= 33'(ev.r2)) : ev.rect_in));
    done_b   = ev_v && !qry_q.is_area && (hit || ev.last_slot);
    flush_go = ev_v && qry_q.is_area && ev.last_slot;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done_b) begin
          state_d = ST_IDLE;
        end else if (rd_cnt_q == LastIdx) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (done_b) begin
          state_d = ST_IDLE;
        end else if (flush_go) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: read issue, scan counter and result to register.
  // An area hit is held back as pending until the next hit or the end of the
  // scan shows whether it is the last result.
  always_comb begin
    rd_issue = 1'b0;
    rd_cnt_d = rd_cnt_q;
    emit_v   = 1'b0;
    emit_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          rd_cnt_d = '0;
        end
      end
      ST_SCAN, ST_WAIT: begin
        if (state_q == ST_SCAN && !done_b) begin
          rd_issue = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (ev_v && !qry_q.is_area) begin
          if (hit) begin
            emit_v             = 1'b1;
            emit_d.found       = 1'b1;
            emit_d.hit_index   = ev.index;
            emit_d.hit_ambient = ev.ambient;
            emit_d.hit_color   = ev.color;
            emit_d.last        = 1'b1;
          end else if (ev.last_slot) begin
            emit_v      = 1'b1;
            emit_d.last = 1'b1;
          end
        end else if (hit && pend_v_q) begin
          emit_v             = 1'b1;
          emit_d.found       = 1'b1;
          emit_d.hit_index   = pend_idx_q;
          emit_d.hit_ambient = pend_amb_q;
          emit_d.hit_color   = pend_col_q;
        end
      end
      ST_FLUSH: begin
        emit_v      = 1'b1;
        emit_d.last = 1'b1;
        if (pend_v_q) begin
          emit_d.found       = 1'b1;
          emit_d.hit_index   = pend_idx_q;
          emit_d.hit_ambient = pend_amb_q;
          emit_d.hit_color   = pend_col_q;
        end
      end
      default: begin
        rd_issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= emit_v;
      if (accept && is_query) begin
        pend_v_q <= 1'b0;
      end else if (hit && qry_q.is_area) begin
        pend_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= emit_d;
    if (hit && qry_q.is_area) begin
      pend_idx_q <= ev.index;
      pend_amb_q <= ev.ambient;
      pend_col_q <= ev.color;
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_v_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ztam_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ztam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ztam_eval.sv -----
// Per-entry evaluation stage: squares, containment and bounding-box tests.
// Depends on ztam_pkg.
`default_nettype none

module ztam_eval
  import ztam_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire tag_t   tag_i,
  input  wire entry_t entry_i,
  input  wire query_t query_i,
  output logic        valid_o,
  output eval_t       eval_o
);

  logic [15:0]        adx, ady;
  logic               rect_in;
  logic signed [17:0] bx0, bx1, by0, by1;
  logic signed [17:0] qx0, qx1, qy0, qy1;
  logic signed [17:0] cx_s, cy_s, rad_s;
  logic               box_ok;
  logic               valid_q;
  eval_t              eval_d, eval_q;

  // Distances are taken as magnitudes so that each square is a 16 by 16 product.
  always_comb begin
    adx = (query_i.x_a >= entry_i.x_a) ? (query_i.x_a - entry_i.x_a)
                                       : (entry_i.x_a - query_i.x_a);
    ady = (query_i.y_a >= entry_i.y_a) ? (query_i.y_a - entry_i.y_a)
                                       : (entry_i.y_a - query_i.y_a);
    rect_in = (query_i.x_a >= entry_i.x_a) && (query_i.x_a <= entry_i.x_b) &&
              (query_i.y_a >= entry_i.y_a) && (query_i.y_a <= entry_i.y_b);
  end

  always_comb begin
    cx_s  = $signed({2'b00, entry_i.x_a});
    cy_s  = $signed({2'b00, entry_i.y_a});
    rad_s = $signed({6'd0, entry_i.radius});
    if (entry_i.is_circle) begin
      bx0 = cx_s - rad_s;
      bx1 = cx_s + rad_s;
      by0 = cy_s - rad_s;
      by1 = cy_s + rad_s;
    end else begin
      bx0 = cx_s;
      by0 = cy_s;
      bx1 = $signed({2'b00, entry_i.x_b});
      by1 = $signed({2'b00, entry_i.y_b});
    end
    qx0 = $signed({2'b00, query_i.x_a});
    qy0 = $signed({2'b00, query_i.y_a});
    qx1 = $signed({2'b00, query_i.x_b});
    qy1 = $signed({2'b00, query_i.y_b});
    box_ok = !((bx1 < qx0) || (bx0 > qx1) || (by1 < qy0) || (by0 > qy1));
  end

  always_comb begin
    eval_d.slot_ok   = tag_i.slot_valid && (entry_i.level == query_i.level);
    eval_d.last_slot = tag_i.last_slot;
    eval_d.index     = tag_i.index;
    eval_d.is_circle = entry_i.is_circle;
    eval_d.rect_in   = rect_in;
    eval_d.box_ok    = box_ok;
    eval_d.dx2       = 32'(adx) * 32'(adx);
    eval_d.dy2       = 32'(ady) * 32'(ady);
    eval_d.r2        = 24'(entry_i.radius) * 24'(entry_i.radius);
    eval_d.ambient   = entry_i.ambient;
    eval_d.color     = entry_i.color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_q <= eval_d;
  end

  assign valid_o = valid_q;
  assign eval_o  = eval_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ztam_checker.sv -----
// Port-level checker for the zone table match unit, bound to the top level.
// Depends on ztam_pkg and the assertion macro header.
`default_nettype none

`include "zone_table_point_and_area_match_unit_macros.svh"

module ztam_checker
  import ztam_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire in_t  item_i,
  input wire out_t result_o,
  input wire logic result_valid_o
);

  `ZTAM_ASSERT_NEXT(a_table_op_stays_idle, start && !busy && (item_i.func == FUNC_WRITE || item_i.func == FUNC_CLEAR), !busy, "write or clear left the unit busy")
  `ZTAM_ASSERT_NEXT(a_query_goes_busy, start && !busy && (item_i.func == FUNC_POINT || item_i.func == FUNC_AREA), busy, "query did not start a scan")
  `ZTAM_ASSERT_SAME(a_miss_is_clean, result_valid_o && !result_o.found, result_o.last && result_o.hit_index == 4'd0 && result_o.hit_ambient == 8'd0 && result_o.hit_color == 8'd0, "not-found result carries data or lacks last")
  `ZTAM_ASSERT_SAME(a_result_from_scan, result_valid_o, $past(busy), "result without a preceding scan")

endmodule

bind zone_table_point_and_area_match_unit ztam_checker u_checker (.*);

`default_nettype wire
